### rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared types for the sector buffer cache tag and LRU controller
// Fixed field widths of the access and result items and their structs.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int SECTOR_IN_W = 32;  // sector field of an access item
	localparam int STAMP_W     = 32;  // use stamp and access counter
	localparam int SLOT_OUT_W  = 6;   // slot field of a result item
	localparam int VICTIM_W    = 32;  // victim sector field of a result item

	// one access, as taken from the slave side
	typedef struct packed {
		logic                   is_write;
		logic [SECTOR_IN_W-1:0] sector;
	} req_t;

	// one result, as handed to the master side
	typedef struct packed {
		logic                  writeback;
		logic                  fetch;
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
		logic [VICTIM_W-1:0]   victim;
	} res_t;

endpackage

### rtl/core/sbc_store.sv
// ----------------------------------------------------------------------------
// sbc_store: entry memory of the sector buffer cache
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbc_store #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 65
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rdata,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/sbc_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_ctrl: lookup and replacement sequencer
// Scans the filled entries one per cycle for a tag match while tracking the
// oldest stamp, then writes back the updated entry and emits the result.
// ----------------------------------------------------------------------------
module sbc_ctrl #(
	parameter int ENTRIES     = 64,
	parameter int SECTOR_BITS = 32,
	parameter int IDX_W       = 6,
	parameter int WORD_W      = 65
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sbc_pkg::req_t     req,
	output logic              idle,
	input  logic              out_free,
	output logic              res_vld,
	output sbc_pkg::res_t     res,
	output logic              mem_rd_en,
	output logic [IDX_W-1:0]  mem_rd_addr,
	input  logic [WORD_W-1:0] mem_rdata,
	output logic              mem_wr_en,
	output logic [IDX_W-1:0]  mem_wr_addr,
	output logic [WORD_W-1:0] mem_wr_data
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int STW   = sbc_pkg::STAMP_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// control
	logic [1:0]       state_q;
	logic [STW-1:0]   counter_q;
	logic [CNT_W-1:0] fill_q;
	logic             issue_q;
	logic             rd_vld_s1;

	// payload
	logic                   is_write_q;
	logic [SECTOR_BITS-1:0] tag_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [IDX_W-1:0]       best_idx_q;
	logic [STW-1:0]         best_stamp_q;
	logic [SECTOR_BITS-1:0] best_tag_q;
	logic                   best_dirty_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       slot_q;
	logic                   old_dirty_q;
	logic                   wb_q;
	logic [sbc_pkg::VICTIM_W-1:0] victim_q;

	// combinational
	logic [SECTOR_BITS-1:0] rd_tag;
	logic [STW-1:0]         rd_stamp;
	logic                   rd_dirty;
	logic                   full;
	logic [IDX_W-1:0]       last_idx;
	logic                   issue_now;
	logic                   hit_now;
	logic                   last_now;
	logic                   take_best;
	logic [IDX_W-1:0]       nb_idx;
	logic [STW-1:0]         nb_stamp;
	logic [SECTOR_BITS-1:0] nb_tag;
	logic                   nb_dirty;
	logic [IDX_W-1:0]       miss_slot;
	logic                   miss_wb;
	logic                   emit;

	assign rd_tag   = mem_rdata[SECTOR_BITS-1:0];
	assign rd_stamp = mem_rdata[SECTOR_BITS +: STW];
	assign rd_dirty = mem_rdata[WORD_W-1];

	assign full      = (fill_q == CNT_W'(ENTRIES));
	assign last_idx  = IDX_W'(fill_q - CNT_W'(1));
	assign issue_now = (state_q == ST_SCAN) && issue_q;
	assign hit_now   = rd_vld_s1 && (rd_tag == tag_q);
	assign last_now  = rd_vld_s1 && (rd_idx_s1 == last_idx);
	// strict compare keeps the lowest slot among equal stamps
	assign take_best = rd_vld_s1 && ((rd_idx_s1 == '0) || (rd_stamp < best_stamp_q));

	assign nb_idx   = take_best ? rd_idx_s1 : best_idx_q;
	assign nb_stamp = take_best ? rd_stamp  : best_stamp_q;
	assign nb_tag   = take_best ? rd_tag    : best_tag_q;
	assign nb_dirty = take_best ? rd_dirty  : best_dirty_q;

	// entries fill from slot zero up and never empty, so the first free one is fill_q
	assign miss_slot = full ? nb_idx : IDX_W'(fill_q);
	assign miss_wb   = full && nb_dirty;

	assign mem_rd_en   = issue_now && !hit_now;
	assign mem_rd_addr = rd_idx_q;

	assign emit        = (state_q == ST_FIN) && out_free;
	assign mem_wr_en   = emit;
	assign mem_wr_addr = slot_q;
	assign mem_wr_data = {is_write_q | (hit_q & old_dirty_q), counter_q + STW'(1), tag_q};

	assign idle          = (state_q == ST_IDLE);
	assign res_vld       = emit;
	assign res.hit       = hit_q;
	assign res.fetch     = !hit_q;
	assign res.writeback = wb_q;
	assign res.slot      = sbc_pkg::SLOT_OUT_W'(slot_q);
	assign res.victim    = victim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			counter_q <= '0;
			fill_q    <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (fill_q == '0) begin
							fill_q  <= CNT_W'(1);
							state_q <= ST_FIN;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue_now && (rd_idx_q == last_idx)) begin
						issue_q <= 1'b0;
					end
					if (hit_now) begin
						issue_q <= 1'b0;
						state_q <= ST_FIN;
					end else if (last_now) begin
						if (!full) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (emit) begin
						counter_q <= counter_q + STW'(1);
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (state_q == ST_IDLE && start) begin
			is_write_q  <= req.is_write;
			tag_q       <= SECTOR_BITS'(req.sector);
			rd_idx_q    <= '0;
			hit_q       <= 1'b0;
			slot_q      <= '0;
			old_dirty_q <= 1'b0;
			wb_q        <= 1'b0;
			victim_q    <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (issue_now && (rd_idx_q != last_idx)) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			best_idx_q   <= nb_idx;
			best_stamp_q <= nb_stamp;
			best_tag_q   <= nb_tag;
			best_dirty_q <= nb_dirty;
			if (hit_now) begin
				hit_q       <= 1'b1;
				slot_q      <= rd_idx_s1;
				old_dirty_q <= rd_dirty;
				wb_q        <= 1'b0;
				victim_q    <= '0;
			end else if (last_now) begin
				hit_q       <= 1'b0;
				slot_q      <= miss_slot;
				old_dirty_q <= 1'b0;
				wb_q        <= miss_wb;
				victim_q    <= miss_wb ? sbc_pkg::VICTIM_W'(nb_tag) : '0;
			end
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr_en && mem_rd_en))
		else $error("entry memory read and written in the same cycle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond the number of entries");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> counter_q == $past(counter_q) + STW'(1))
		else $error("access counter did not advance on a result");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == ST_SCAN)
		else $error("read data returned outside the scan");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && res.hit) |-> (!res.writeback && res.victim == '0))
		else $error("write-back reported on a hit");

endmodule

### rtl/core/sector_buffer_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// sector_buffer_cache_lru_unit: tag and LRU controller of a sector cache
// Fully associative write-back lookup with use-stamp replacement.
//
//  channel  | dir | data                              | user
//  ---------+-----+-----------------------------------+-------------------------
//  s_*      | in  | [31:0] sector                     | [0] action (1 = write)
//  m_*      | out | [5:0] slot, [37:6] victim_sector  | [0] hit, [1] fetch,
//           |     | [39:38] zero                      | [2] writeback
//
// A miss scans every filled entry of the entry memory, one entry per cycle,
// before its result is shown; a hit in slot k ends the scan at that slot.
// The first access into an empty cache skips the scan. The next item can be
// taken once a result is loaded into the output register. Reset clears the
// fill count and the access counter; the entry memory needs no clearing
// pass, as only filled entries are ever read. A result waits in the output
// register while the next item is accepted and scanned; a stalled master
// holds the sequencer in its final cycle.
// ----------------------------------------------------------------------------
module sector_buffer_cache_lru_unit #(
	parameter int ENTRIES     = 64,
	parameter int SECTOR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sector
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [5:0] slot, [37:6] victim_sector, [39:38] zero
	output logic [2:0]  m_tuser    // [0] hit, [1] fetch, [2] writeback
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int WORD_W = SECTOR_BITS + sbc_pkg::STAMP_W + 1;

	sbc_pkg::req_t req;
	sbc_pkg::res_t res;
	sbc_pkg::res_t res_q;
	logic          m_tvalid_q;
	logic          idle;
	logic          out_free;
	logic          res_vld;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_addr;
	logic [WORD_W-1:0] mem_rdata;
	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_addr;
	logic [WORD_W-1:0] mem_wr_data;

	assign req.is_write = s_tuser[0];
	assign req.sector   = s_tdata;
	assign s_tready     = idle;
	assign out_free     = !m_tvalid_q || m_tready;

	sbc_ctrl #(
		.ENTRIES     (ENTRIES),
		.SECTOR_BITS (SECTOR_BITS),
		.IDX_W       (IDX_W),
		.WORD_W      (WORD_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (s_tvalid && idle),
		.req         (req),
		.idle        (idle),
		.out_free    (out_free),
		.res_vld     (res_vld),
		.res         (res),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rdata   (mem_rdata),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	sbc_store #(
		.DEPTH  (ENTRIES),
		.ADDR_W (IDX_W),
		.DATA_W (WORD_W)
	) u_store (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rdata   (mem_rdata),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wdata   (mem_wr_data)
	);

	// output register: load a new result, drop the valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_vld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.victim, res_q.slot};
	assign m_tuser  = {res_q.writeback, res_q.fetch, res_q.hit};

endmodule

### test/sector_buffer_cache_lru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_buffer_cache_lru_checker: lookup predictor and result comparator
// Mirrors the tag, valid, dirty and stamp state of the cache, works out the
// lookup result of every accepted access and compares it with the results
// leaving the master side, oldest first.
// ----------------------------------------------------------------------------
module sector_buffer_cache_lru_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sector
	input  logic [0:0]  s_tuser,   // [0] action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [5:0] slot, [37:6] victim_sector, [39:38] zero
	input  logic [2:0]  m_tuser,   // [0] hit, [1] fetch, [2] writeback
	output int          error_count,
	output int          outstanding,
	output int          hit_count,
	output int          evict_wb_count
);

	localparam int ENTRIES    = 64;
	localparam int MAX_PRINTS = 40;

	logic [sbc_pkg::SECTOR_IN_W-1:0] line_tag   [ENTRIES];
	bit                              line_valid [ENTRIES];
	bit                              line_dirty [ENTRIES];
	bit   [sbc_pkg::STAMP_W-1:0]     line_stamp [ENTRIES];
	bit   [sbc_pkg::STAMP_W-1:0]     use_count;

	sbc_pkg::res_t lookup_results_q[$];

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("%0t ns MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Look up one access and update the mirrored cache state.
	function automatic sbc_pkg::res_t predict_lookup(input logic is_write,
			input logic [sbc_pkg::SECTOR_IN_W-1:0] sector);
		sbc_pkg::res_t r;
		int            way;
		int            oldest;
		r      = '0;
		way    = -1;
		oldest = 0;
		use_count = use_count + 1'b1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (way < 0 && line_valid[i] && line_tag[i] == sector)
				way = i;
		end
		r.hit = (way >= 0);
		if (way < 0) begin
			// take the lowest empty way, else the smallest stamp, lowest way on a tie
			for (int i = 0; i < ENTRIES; i++) begin
				if (way < 0) begin
					if (!line_valid[i])
						way = i;
					else if (line_stamp[i] < line_stamp[oldest])
						oldest = i;
				end
			end
			if (way < 0)
				way = oldest;
			if (line_valid[way] && line_dirty[way]) begin
				r.writeback = 1'b1;
				r.victim    = line_tag[way];
				evict_wb_count++;
			end
			line_tag[way]   = sector;
			line_valid[way] = 1'b1;
			line_dirty[way] = 1'b0;
		end else begin
			hit_count++;
		end
		r.fetch = !r.hit;
		r.slot  = way[sbc_pkg::SLOT_OUT_W-1:0];
		line_stamp[way] = use_count;
		if (is_write)
			line_dirty[way] = 1'b1;
		return r;
	endfunction

	task automatic check_result();
		sbc_pkg::res_t want;
		if (lookup_results_q.size() == 0) begin
			report_mismatch($sformatf("result with no access outstanding, tdata 0x%0h",
				m_tdata));
			return;
		end
		want = lookup_results_q.pop_front();
		check_field("hit", 32'(m_tuser[0]), 32'(want.hit));
		check_field("fetch", 32'(m_tuser[1]), 32'(want.fetch));
		check_field("writeback", 32'(m_tuser[2]), 32'(want.writeback));
		check_field("slot", 32'(m_tdata[5:0]), 32'(want.slot));
		check_field("victim_sector", m_tdata[37:6], want.victim);
	endtask

	// retire the result before queuing the new access: it belongs to an older item
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				lookup_results_q.push_back(predict_lookup(s_tuser[0], s_tdata));
			outstanding = lookup_results_q.size();
		end
	end

endmodule

### test/sector_buffer_cache_lru_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_buffer_cache_lru_unit_tb: stimulus and verdict for the sector cache
// Drives read and write accesses over a mix of recurring and fresh sectors so
// that hits, fills, clean and dirty evictions all occur, with random idle
// gaps on both sides, a long output stall and drain pauses. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sector_buffer_cache_lru_unit_tb;

	localparam logic ACT_READ     = 1'b0;
	localparam logic ACT_WRITE    = 1'b1;
	localparam int   POOL_SIZE    = 96;
	localparam int   BLOCKS       = 11;
	localparam int   BLOCK_ITEMS  = 50;
	localparam int   RX_HOLD_CYC  = 600;
	localparam int   DRAIN_CYC    = 100;
	localparam int   CYCLE_LIMIT  = 500000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] sector
	logic [0:0]  s_tuser;   // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [5:0] slot, [37:6] victim_sector, [39:38] zero
	logic [2:0]  m_tuser;   // [0] hit, [1] fetch, [2] writeback

	int error_count;
	int outstanding;
	int hit_count;
	int evict_wb_count;

	int          cycle_count = 0;
	int          access_count = 0;
	int          tx_gap_max = 0;
	int          rx_gap_max = 0;
	bit          rx_hold = 1'b0;
	logic [31:0] sector_pool [POOL_SIZE];

	sector_buffer_cache_lru_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sector_buffer_cache_lru_checker lookup_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.error_count    (error_count),
		.outstanding    (outstanding),
		.hit_count      (hit_count),
		.evict_wb_count (evict_wb_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Test completed with failures");
		$finish;
	end

	// Offer one access after a random gap and hold it until taken.
	task automatic send_access(input logic action, input logic [31:0] sector);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sector;
		s_tuser  <= action;
		do @(posedge clk); while (!s_tready);
		access_count++;
		@(negedge clk);
	endtask

	// Receiver: random gap before each result, one long stall on request.
	initial begin
		int wait_n;
		bit held;
		held     = 1'b0;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold && !held) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYC) @(negedge clk);
				held = 1'b1;
			end
			wait_n = $urandom_range(0, rx_gap_max);
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		int          span;
		logic [31:0] sector;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_READ;
		for (int i = 0; i < POOL_SIZE; i++)
			sector_pool[i] = (i < 8) ? (32'h8000_0000 >> i) ^ i : $urandom();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, read and write on hit and miss
		send_access(ACT_READ,  32'h0000_0000);   // first fill takes the lowest way
		send_access(ACT_WRITE, 32'hFFFF_FFFF);   // write miss: fetch, then dirty
		send_access(ACT_READ,  32'h0000_0000);
		send_access(ACT_WRITE, 32'h0000_0000);   // write hit marks dirty
		send_access(ACT_READ,  32'hFFFF_FFFF);
		send_access(ACT_WRITE, 32'hAAAA_AAAA);
		send_access(ACT_READ,  32'h5555_5555);
		send_access(ACT_WRITE, 32'h8000_0000);
		send_access(ACT_READ,  32'h0000_0001);
		send_access(ACT_WRITE, 32'h5555_5555);
		send_access(ACT_READ,  32'hAAAA_AAAA);
		send_access(ACT_WRITE, 32'hFFFF_FFFF);
		send_access(ACT_READ,  32'h8000_0000);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		// random: recurring sectors for hits and evictions, fresh ones for misses
		for (int b = 0; b < BLOCKS; b++) begin
			case (b % 4)
				0: begin tx_gap_max = 0; rx_gap_max = 0; end
				1: begin tx_gap_max = 9; rx_gap_max = 9; end
				2: begin tx_gap_max = 0; rx_gap_max = 9; end
				default: begin tx_gap_max = 9; rx_gap_max = 2; end
			endcase
			if (b == 0)
				tx_gap_max = 0;
			if (b == 2)
				rx_hold = 1'b1;
			if (b == 6) begin
				// let the cache drain before going on
				s_tvalid <= 1'b0;
				wait (outstanding == 0);
				@(negedge clk);
			end
			span = ($urandom_range(0, 1) == 0) ? 40 : POOL_SIZE;
			for (int k = 0; k < BLOCK_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 75)
					sector = sector_pool[$urandom_range(0, span - 1)];
				else
					sector = $urandom();
				send_access($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, sector);
			end
		end
		s_tvalid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Covered %0d accesses: %0d hits, %0d misses, %0d dirty write-backs",
			access_count, hit_count, access_count - hit_count, evict_wb_count);
		$display("with idle gaps on both sides, a %0d-cycle output stall and drain pauses",
			RX_HOLD_CYC);
		if (error_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
